FILE: rtl/core/tspcb_pkg.sv
// ----------------------------------------------------------------------------
// tspcb_pkg: shared types and constants for the child breed-and-score block
// Transaction payload structs, opcodes and road table geometry.
// ----------------------------------------------------------------------------
package tspcb_pkg;

  // Input transaction opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_BREED  = 2'd2;

  // Road table: 16 x 16 directed entries, addressed {from, to}
  localparam int CITY_W      = 4;
  localparam int TABLE_ADDR_W = 2 * CITY_W;
  localparam int TABLE_DEPTH = 1 << TABLE_ADDR_W;

  // Tour and result widths
  localparam int TOUR_W   = 64;
  localparam int LENGTH_W = 20;
  localparam int COUNT_W  = 5;

  // Configuration register indexes
  localparam logic REG_CITY_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [CITY_W-1:0]   from_city;
    logic [CITY_W-1:0]   to_city;
    logic [15:0]         road_length;
    logic [TOUR_W-1:0]   parent_a_tour;
    logic [TOUR_W-1:0]   parent_b_tour;
    logic                swap_enable;
    logic [CITY_W-1:0]   swap_first;
    logic [CITY_W-1:0]   swap_second;
  } in_item_t;

  typedef struct packed {
    logic [TOUR_W-1:0]   child_tour;
    logic [LENGTH_W-1:0] tour_length;
    logic                unreachable;
  } out_item_t;

endpackage

FILE: rtl/core/tspcb_road_table.sv
// ----------------------------------------------------------------------------
// tspcb_road_table: directed road length store
// One write port and one registered read port; per-entry valid flops.
// ----------------------------------------------------------------------------
module tspcb_road_table #(
  parameter int DIST_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic                              wr_set,
  input  logic [tspcb_pkg::TABLE_ADDR_W-1:0] wr_addr,
  input  logic [DIST_BITS-1:0]              wr_len,
  input  logic [tspcb_pkg::TABLE_ADDR_W-1:0] rd_addr,
  output logic                              rd_hit,
  output logic [DIST_BITS-1:0]              rd_len
);

  logic [tspcb_pkg::TABLE_DEPTH-1:0] valid_bits;
  logic [DIST_BITS-1:0]              mem [tspcb_pkg::TABLE_DEPTH];

  // Valid flops clear at reset: every road starts absent
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_hit     <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_bits[wr_addr] <= wr_set;
      end
      rd_hit <= valid_bits[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_set) begin
      mem[wr_addr] <= wr_len;
    end
    rd_len <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/tsp_child_breed_and_score_top.sv
// ----------------------------------------------------------------------------
// tsp_child_breed_and_score_top: order-crossover child builder and scorer
// Holds a directed road table, breeds a child tour from two parents and
// returns the closed tour length.
// ----------------------------------------------------------------------------
// A write or remove transaction updates at most one road of the table on its
// accept edge. A breed transaction starts at the accept edge, which loads the
// working registers, and then runs through the crossover scan over at most n
// live cities of parent B (one parent B city per cycle), the step that leaves
// the scan, the mutation swap, one table read per child position through the
// single read port of the road table, a drain of the read pipeline and the
// hand-off to the output register, which waits while that register still holds
// an unclaimed result. The input is not ready while a breed is in flight and
// becomes ready again in the cycle the result appears; a finished result waits
// in the output register so a new transaction can enter while it is still
// unclaimed. Roads whose sum passes 20 bits saturate the length to all ones; a
// missing road also raises unreachable.
module tsp_child_breed_and_score_top #(
  parameter int MAX_CITIES = 16,
  parameter int DIST_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input transaction channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tspcb_pkg::in_item_t  in_data,
  // result transaction channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output tspcb_pkg::out_item_t out_data
);

  localparam int CW     = tspcb_pkg::CITY_W;
  localparam int NW     = tspcb_pkg::COUNT_W;
  localparam int LW     = tspcb_pkg::LENGTH_W;
  localparam int SUM_W  = ((DIST_BITS > LW) ? DIST_BITS : LW) + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SWAP   = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                  state;
  logic [NW-1:0]               city_count;
  logic [NW-1:0]               n_live;

  // Working copy of the transaction
  logic [tspcb_pkg::TOUR_W-1:0] parent_b;
  logic                        swap_en;
  logic [CW-1:0]               swap_a;
  logic [CW-1:0]               swap_b;

  logic [tspcb_pkg::TOUR_W-1:0] child;
  logic [(1 << CW)-1:0]        present;
  logic [NW-1:0]               fill;
  logic [NW-1:0]               idx;

  // Accumulator
  logic [LW-1:0]               acc;
  logic                        acc_ovf;
  logic                        broken;
  logic                        rd_pend;

  logic                        in_fire;
  logic                        wr_en;
  logic                        wr_set;
  logic [CW-1:0]               scan_city;
  logic [NW-1:0]               idx_inc;
  logic [CW-1:0]               next_pos;
  logic [tspcb_pkg::TABLE_ADDR_W-1:0] rd_addr;
  logic                        rd_hit;
  logic [DIST_BITS-1:0]        rd_len;
  logic [SUM_W-1:0]            acc_ext;
  logic                        swap_ok;
  logic                        out_free;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= NW'(8);
    end else if (psel && penable && pwrite && paddr[2] == tspcb_pkg::REG_CITY_COUNT) begin
      city_count <= pwdata[NW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tspcb_pkg::REG_CITY_COUNT) begin
      prdata[NW-1:0] = city_count;
    end
  end

  // Clamp the programmed count into 2..MAX_CITIES
  always_comb begin
    if (city_count < NW'(2)) begin
      n_live = NW'(2);
    end else if (city_count > NW'(MAX_CITIES)) begin
      n_live = NW'(MAX_CITIES);
    end else begin
      n_live = city_count;
    end
  end

  // ------------------------------------------------------------ road table
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Road updates land on the accept edge; out-of-range roads are dropped
  assign wr_set = (in_data.opcode == tspcb_pkg::OP_WRITE);
  assign wr_en  = in_fire
                  && (in_data.opcode == tspcb_pkg::OP_WRITE
                      || in_data.opcode == tspcb_pkg::OP_REMOVE)
                  && ({1'b0, in_data.from_city} < n_live)
                  && ({1'b0, in_data.to_city} < n_live);

  // Edge from position idx to the next filled position, wrapping to 0
  assign idx_inc  = idx + NW'(1);
  assign next_pos = (idx_inc < fill) ? idx_inc[CW-1:0] : '0;
  assign rd_addr  = {child[idx[CW-1:0]*CW +: CW], child[next_pos*CW +: CW]};

  tspcb_road_table #(
    .DIST_BITS (DIST_BITS)
  ) u_road_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_set  (wr_set),
    .wr_addr ({in_data.from_city, in_data.to_city}),
    .wr_len  (DIST_BITS'(in_data.road_length)),
    .rd_addr (rd_addr),
    .rd_hit  (rd_hit),
    .rd_len  (rd_len)
  );

  // Accumulator adder: one road length per cycle, sticky overflow above 20 bits
  assign acc_ext = SUM_W'(acc) + SUM_W'(rd_len);

  assign scan_city = parent_b[idx[CW-1:0]*CW +: CW];
  assign swap_ok   = swap_en && (swap_a != swap_b)
                     && (swap_a != '0) && (swap_b != '0)
                     && ({1'b0, swap_a} < fill) && ({1'b0, swap_b} < fill);
  assign out_free  = !out_valid || out_ready;

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && in_data.opcode == tspcb_pkg::OP_BREED) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Stop once the child is full or parent B is exhausted
          if (fill >= n_live || idx >= n_live) begin
            state <= S_SWAP;
          end
        end
        S_SWAP: begin
          state <= S_SUM;
        end
        S_SUM: begin
          rd_pend <= 1'b1;
          if (idx_inc >= fill) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // Hold the result until the output register frees up
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (rd_hit) begin
        acc <= acc_ext[LW-1:0];
        if (acc_ext[SUM_W-1:LW] != '0) begin
          acc_ovf <= 1'b1;
        end
      end else begin
        broken <= 1'b1;
      end
    end
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          parent_b <= in_data.parent_b_tour;
          swap_en  <= in_data.swap_enable;
          swap_a   <= in_data.swap_first;
          swap_b   <= in_data.swap_second;
          child    <= {{(tspcb_pkg::TOUR_W - 2*CW){1'b0}},
                       in_data.parent_a_tour[2*CW-1:0]};
          present  <= ((1 << CW)'(1) << in_data.parent_a_tour[CW-1:0])
                    | ((1 << CW)'(1) << in_data.parent_a_tour[2*CW-1:CW]);
          fill     <= NW'(2);
          idx      <= '0;
          acc      <= '0;
          acc_ovf  <= 1'b0;
          broken   <= 1'b0;
        end
      end
      S_SCAN: begin
        if (!(fill >= n_live || idx >= n_live)) begin
          if (!present[scan_city]) begin
            child[fill[CW-1:0]*CW +: CW] <= scan_city;
            present[scan_city]           <= 1'b1;
            fill                         <= fill + NW'(1);
          end
          idx <= idx_inc;
        end
      end
      S_SWAP: begin
        if (swap_ok) begin
          child[swap_a*CW +: CW] <= child[swap_b*CW +: CW];
          child[swap_b*CW +: CW] <= child[swap_a*CW +: CW];
        end
        idx <= '0;
      end
      S_SUM: begin
        idx <= idx_inc;
      end
      S_FINISH: begin
        if (out_free) begin
          out_data.child_tour  <= child;
          out_data.tour_length <= (broken || acc_ovf) ? {LW{1'b1}} : acc;
          out_data.unreachable <= broken;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: test/tspcb_checker.sv
// ----------------------------------------------------------------------------
// tspcb_checker: child breed-and-score result checker
// Tracks the road table and city count, predicts every breed result and
// compares it field by field with the result channel.
// ----------------------------------------------------------------------------
module tspcb_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  tspcb_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  tspcb_pkg::out_item_t out_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_CITIES       = 16;
  localparam int          SUM_W            = 24;
  localparam int          QUEUE_DEPTH      = 16;
  localparam logic [4:0]  CITY_COUNT_RESET = 5'd8;
  localparam logic [2:0]  CITY_COUNT_ADDR  = 3'(4 * tspcb_pkg::REG_CITY_COUNT);

  logic                          road_ok  [16][16];
  logic [15:0]                   road_len [16][16];
  logic [tspcb_pkg::COUNT_W-1:0] city_cnt;
  // Ring of predicted results, oldest at head
  tspcb_pkg::out_item_t          expected_children [QUEUE_DEPTH];
  int unsigned                   head_cnt;
  int unsigned                   tail_cnt;

  function automatic int unsigned live_count();
    if (city_cnt < 2) return 2;
    if (city_cnt > MAX_CITIES) return MAX_CITIES;
    return city_cnt;
  endfunction

  // Order crossover, optional swap, then the closed tour sum.
  function automatic tspcb_pkg::out_item_t score_child(tspcb_pkg::in_item_t it);
    logic [3:0]           kid [16];
    int unsigned          n, fill, i, j, s1, s2;
    logic                 seen, broken;
    logic [3:0]           c, a, b, t;
    logic [SUM_W-1:0]     sum;
    tspcb_pkg::out_item_t res;
    n = live_count();
    for (i = 0; i < 16; i++) kid[i] = '0;
    kid[0] = it.parent_a_tour[3:0];
    kid[1] = it.parent_a_tour[7:4];
    fill = 2;
    for (i = 0; i < n && fill < n; i++) begin
      c = it.parent_b_tour[4*i +: 4];
      seen = 1'b0;
      for (j = 0; j < fill; j++) if (kid[j] == c) seen = 1'b1;
      if (!seen) begin
        kid[fill] = c;
        fill++;
      end
    end
    s1 = it.swap_first;
    s2 = it.swap_second;
    if (it.swap_enable && s1 != s2 && s1 >= 1 && s2 >= 1 && s1 < fill && s2 < fill) begin
      t = kid[s1];
      kid[s1] = kid[s2];
      kid[s2] = t;
    end
    res = '0;
    sum = '0;
    broken = 1'b0;
    for (i = 0; i < fill; i++) begin
      a = kid[i];
      b = kid[(i + 1 < fill) ? i + 1 : 0];
      res.child_tour[4*i +: 4] = a;
      if (!road_ok[a][b]) broken = 1'b1;
      else sum = sum + road_len[a][b];
    end
    res.unreachable = broken;
    res.tour_length = (broken || sum > {tspcb_pkg::LENGTH_W{1'b1}}) ? '1
                      : sum[tspcb_pkg::LENGTH_W-1:0];
    return res;
  endfunction

  // Append one predicted result behind the ones still owed
  function automatic void queue_child(tspcb_pkg::out_item_t child);
    expected_children[tail_cnt % QUEUE_DEPTH] = child;
    tail_cnt++;
  endfunction

  function automatic void take_item(tspcb_pkg::in_item_t it);
    int unsigned n;
    n = live_count();
    case (it.opcode)
      tspcb_pkg::OP_WRITE: begin
        if (it.from_city < n && it.to_city < n) begin
          road_ok[it.from_city][it.to_city]  = 1'b1;
          road_len[it.from_city][it.to_city] = it.road_length;
        end
      end
      tspcb_pkg::OP_REMOVE: begin
        if (it.from_city < n && it.to_city < n) begin
          road_ok[it.from_city][it.to_city]  = 1'b0;
          road_len[it.from_city][it.to_city] = '0;
        end
      end
      tspcb_pkg::OP_BREED: queue_child(score_child(it));
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    tspcb_pkg::out_item_t want;
    int f, t;
    if (rst) begin
      city_cnt = CITY_COUNT_RESET;
      for (f = 0; f < 16; f++) begin
        for (t = 0; t < 16; t++) begin
          road_ok[f][t]  = 1'b0;
          road_len[f][t] = '0;
        end
      end
      head_cnt = 0;
      tail_cnt = 0;
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tail_cnt == head_cnt) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = expected_children[head_cnt % QUEUE_DEPTH];
          head_cnt++;
          if (out_data.child_tour !== want.child_tour) begin
            $display("%0t: child_tour expected %h actual %h",
                     $time, want.child_tour, out_data.child_tour);
            errors++;
          end
          if (out_data.tour_length !== want.tour_length) begin
            $display("%0t: tour_length expected %h actual %h",
                     $time, want.tour_length, out_data.tour_length);
            errors++;
          end
          if (out_data.unreachable !== want.unreachable) begin
            $display("%0t: unreachable expected %b actual %b",
                     $time, want.unreachable, out_data.unreachable);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) take_item(in_data);
      if (psel && penable && pwrite && pready && paddr == CITY_COUNT_ADDR)
        city_cnt = pwdata[tspcb_pkg::COUNT_W-1:0];
    end
    pending = int'(tail_cnt - head_cnt);
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the child breed-and-score block
// Drives road writes, removes and breed transactions under random idling on
// both channels, steps the city count through its extremes between phases,
// and prints the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused opcode: the block ignores it and returns nothing
  localparam logic [1:0]  OP_IDLE         = 2'd3;
  localparam logic [2:0]  CITY_COUNT_ADDR = 3'(4 * tspcb_pkg::REG_CITY_COUNT);
  // Tour 0,1,2,...,15 with position 0 in the low nibble
  localparam logic [63:0] IDENT_TOUR      = 64'hFEDC_BA98_7654_3210;
  localparam int          MAX_GAP         = 16;
  // Margin after the last result before the city count changes
  localparam int          SETTLE_CYCLES   = 48;
  localparam int          PHASE_ITEMS     = 16;
  localparam int          PHASES          = 10;
  localparam int          CYCLE_LIMIT     = 300000;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [2:0]           paddr    = '0;
  logic [31:0]          pwdata   = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tspcb_pkg::in_item_t  in_data  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tspcb_pkg::out_item_t out_data;

  int   fail_count;
  int   results_owed;
  int   cycle_count = 0;
  // When set, neither side idles: back-to-back stretches
  logic steady = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tsp_child_breed_and_score_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tspcb_checker score_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (fail_count),
    .pending   (results_owed)
  );

  // Idle cycles before the next transaction on either side
  function automatic int unsigned draw_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Every field random; callers overwrite what matters
  function automatic tspcb_pkg::in_item_t noise_item();
    tspcb_pkg::in_item_t it;
    it.opcode        = 2'($urandom_range(0, 3));
    it.from_city     = 4'($urandom);
    it.to_city       = 4'($urandom);
    it.road_length   = 16'($urandom);
    it.parent_a_tour = {$urandom, $urandom};
    it.parent_b_tour = {$urandom, $urandom};
    it.swap_enable   = 1'($urandom);
    it.swap_first    = 4'($urandom);
    it.swap_second   = 4'($urandom);
    return it;
  endfunction

  function automatic tspcb_pkg::in_item_t road_item(logic [1:0] op, logic [3:0] from_c,
                                                    logic [3:0] to_c, logic [15:0] len);
    tspcb_pkg::in_item_t it;
    it = noise_item();
    it.opcode      = op;
    it.from_city   = from_c;
    it.to_city     = to_c;
    it.road_length = len;
    return it;
  endfunction

  function automatic tspcb_pkg::in_item_t breed_item(logic [63:0] tour_a,
                                                     logic [63:0] tour_b,
                                                     logic en, logic [3:0] first,
                                                     logic [3:0] second);
    tspcb_pkg::in_item_t it;
    it = noise_item();
    it.opcode        = tspcb_pkg::OP_BREED;
    it.parent_a_tour = tour_a;
    it.parent_b_tour = tour_b;
    it.swap_enable   = en;
    it.swap_first    = first;
    it.swap_second   = second;
    return it;
  endfunction

  // City 0 first, a shuffle of 1..n-1 behind it, random nibbles past n
  function automatic logic [63:0] make_tour(int unsigned n);
    logic [3:0]  city [16];
    logic [3:0]  t;
    logic [63:0] w;
    int unsigned i, j;
    for (i = 0; i < 16; i++) city[i] = 4'(i);
    for (i = n - 1; i > 1; i--) begin
      j = $urandom_range(1, i);
      t = city[i];
      city[i] = city[j];
      city[j] = t;
    end
    w = {$urandom, $urandom};
    for (i = 0; i < n; i++) w[4*i +: 4] = city[i];
    return w;
  endfunction

  // Mostly well-formed breeds; some broken parents, noise, road edits
  function automatic tspcb_pkg::in_item_t random_item(int unsigned n);
    tspcb_pkg::in_item_t it;
    int unsigned         pick, pos;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      it.opcode = tspcb_pkg::OP_BREED;
      if (pick < 60) begin
        it.parent_a_tour = make_tour(n);
        it.parent_b_tour = make_tour(n);
        if (pick < 12) begin
          // stray city in parent B: may repeat one or leave a gap
          pos = $urandom_range(0, n - 1);
          it.parent_b_tour[4*pos +: 4] = 4'($urandom);
        end else if (pick < 18) begin
          it.parent_a_tour[7:4] = it.parent_a_tour[3:0];
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        it.swap_first  = 4'($urandom_range(1, n - 1));
        it.swap_second = 4'($urandom_range(1, n - 1));
      end
    end else if (pick < 95) begin
      it.opcode = (pick < 85) ? tspcb_pkg::OP_WRITE : tspcb_pkg::OP_REMOVE;
      if ($urandom_range(0, 7) != 0) begin
        it.from_city = 4'($urandom_range(0, n - 1));
        it.to_city   = 4'($urandom_range(0, n - 1));
      end
    end else begin
      it.opcode = OP_IDLE;
    end
    return it;
  endfunction

  // Present one transaction and hold it until accepted. Leave valid high so
  // the next call at the same step can follow without a gap.
  task automatic offer(input tspcb_pkg::in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every owed result, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access cycle; the register takes the value on the edge that ends the access cycle
  task automatic set_city_count(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CITY_COUNT_ADDR;
    pwdata  <= ($urandom & 32'hFFFF_FFE0) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write every road among the live cities, self roads included
  task automatic load_roads(input int unsigned n, input logic longest);
    int unsigned f, t;
    for (f = 0; f < n; f++)
      for (t = 0; t < n; t++)
        offer(road_item(tspcb_pkg::OP_WRITE, 4'(f), 4'(t),
                        longest ? 16'hFFFF : 16'($urandom)));
  endtask

  // Result side: stall a random number of cycles, then hold ready until a
  // transaction moves.
  initial begin
    int unsigned gap;
    wait (!rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    tspcb_pkg::in_item_t ones;
    int unsigned         phase, value, n, loaded_n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset city count of 8.
    // No road yet: every edge of the tour is missing.
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b0, 4'd0, 4'd0));
    load_roads(8, 1'b0);
    loaded_n = 8;
    // Longest and shortest road lengths, then tours that use them
    offer(road_item(tspcb_pkg::OP_WRITE, 4'd3, 4'd5, 16'hFFFF));
    offer(road_item(tspcb_pkg::OP_WRITE, 4'd5, 4'd3, 16'h0000));
    offer(breed_item(IDENT_TOUR, 64'hFEDC_BA98_7645_3210, 1'b0, 4'd0, 4'd0));
    offer(breed_item(IDENT_TOUR, 64'hFEDC_BA98_7643_5210, 1'b0, 4'd0, 4'd0));
    // Roads outside the live cities: both dropped
    offer(road_item(tspcb_pkg::OP_WRITE, 4'd12, 4'd2, 16'h1234));
    offer(road_item(tspcb_pkg::OP_REMOVE, 4'd3, 4'd9, 16'h0000));
    // Repeated start city keeps both copies and rides the self road
    offer(breed_item(64'hFEDC_BA98_7654_3200, IDENT_TOUR, 1'b0, 4'd0, 4'd0));
    // Parent B adds nothing new: two-city child, swap past the fill refused
    offer(breed_item(IDENT_TOUR, 64'h0, 1'b1, 4'd1, 4'd2));
    // Swap bounds: legal, position 0, equal, past the end, disabled
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b1, 4'd1, 4'd7));
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b1, 4'd0, 4'd3));
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b1, 4'd4, 4'd4));
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b1, 4'd2, 4'd8));
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b0, 4'd2, 4'd5));
    // Missing road, then restore it
    offer(road_item(tspcb_pkg::OP_REMOVE, 4'd0, 4'd1, 16'h0000));
    offer(breed_item(IDENT_TOUR, IDENT_TOUR, 1'b0, 4'd0, 4'd0));
    offer(road_item(tspcb_pkg::OP_WRITE, 4'd0, 4'd1, 16'hFFFF));
    // All fields high: unused opcode, then a breed over an unreachable city
    ones = '1;
    offer(ones);
    ones.opcode = tspcb_pkg::OP_BREED;
    offer(ones);
    offer(breed_item(64'h0, 64'h0, 1'b0, 4'd0, 4'd0));

    // Random phases. Walk the city count through the clamps at both ends.
    // Roads persist across phases, so load only when the count grows past
    // what is already loaded; the first phase at 16 loads every road at its
    // longest length.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: value = 2;
        1: value = 16;
        2: value = 0;
        3: value = 31;
        4: value = 1;
        5: value = 17;
        6: value = 3;
        9: value = 8;
        default: value = $urandom_range(2, 16);
      endcase
      n = (value < 2) ? 2 : (value > 16) ? 16 : value;
      steady = ($urandom_range(0, 3) == 0);
      set_city_count(5'(value));
      if (n > loaded_n) begin
        load_roads(n, value == 16);
        loaded_n = n;
      end
      repeat (PHASE_ITEMS) offer(random_item(n));
    end
    settle();

    if (fail_count == 0) begin
      $display("tsp_child_breed_and_score_top verification clean");
    end else begin
      $display("tsp_child_breed_and_score_top verification failed");
    end
    $finish;
  end

  // Hang guard: a lost result or a stuck handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tsp_child_breed_and_score_top verification failed");
      $finish;
    end
  end

endmodule
